### hdl/selq_pkg.sv
// Package for the shared/exclusive lock queue: depth, widths, opcodes,
// status codes and the queue entry type. No dependencies.
`timescale 1ns / 1ps
package selq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOCK   = 2'd0,
    OP_UNLOCK = 2'd1,
    OP_SCAN   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  localparam logic [3:0] ST_GRANTED     = 4'd0;
  localparam logic [3:0] ST_QUEUED      = 4'd1;
  localparam logic [3:0] ST_HELD        = 4'd2;
  localparam logic [3:0] ST_FULL        = 4'd3;
  localparam logic [3:0] ST_UNLOCKED    = 4'd4;
  localparam logic [3:0] ST_NOT_OWNER   = 4'd5;
  localparam logic [3:0] ST_NOT_FOUND   = 4'd6;
  localparam logic [3:0] ST_NEW_GRANT   = 4'd7;
  localparam logic [3:0] ST_SCAN_DONE   = 4'd8;
  localparam logic [3:0] ST_CLEARED     = 4'd9;

  typedef struct packed {
    logic [31:0] ref_w;
    logic [31:0] data_w;
    logic [31:0] extra_w;
    logic        shared;
    logic        granted;
  } entry_t;
endpackage

### hdl/shared_exclusive_lock_queue.sv
// Shared/exclusive lock request queue, top level with its sequencer.
// Lock: one beat; a refused try-lock with notify also reports the owner.
// Unlock: searches from the head; on a match, later entries shift down one
// place to close the gap. Clear: empties the queue in one beat.
// Scan: walks from the head until the queue ends or a later entry and the one
// before it are not both shared; one beat per new grant plus a closing beat.
// Reset empties the queue at once; entry contents need no clearing.
// Depends on selq_pkg and selq_ram.
`timescale 1ns / 1ps
module shared_exclusive_lock_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_requester_ref,
  input  logic [31:0] in_requester_data,
  input  logic        in_want_shared,
  input  logic        in_try_only,
  input  logic        in_notify_owner,
  input  logic [31:0] in_extra_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_status,
  output logic [31:0] out_peer_ref,
  output logic [31:0] out_peer_data,
  output logic [31:0] out_peer_extra,
  output logic        out_peer_shared,
  output logic        out_peer_valid,
  output logic        out_last_result
);
  localparam int IW = selq_pkg::IDX_W;
  localparam int CW = selq_pkg::CNT_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(selq_pkg::QUEUE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_LREAD  = 9'b000000010,
    S_LDEC   = 9'b000000100,
    S_UREAD  = 9'b000001000,
    S_UCHK   = 9'b000010000,
    S_SHREAD = 9'b000100000,
    S_SHWR   = 9'b001000000,
    S_SREAD  = 9'b010000000,
    S_SCHK   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [1:0] op_r;
  logic [31:0] ref_r, data_r, extra_r;
  logic shared_r, try_r, notify_r;
  logic prev_shared_r, prev_shared_nxt;

  logic ov_r, ov_nxt;
  logic [3:0] ost_r, ost_nxt;
  selq_pkg::entry_t ope_r, ope_nxt;
  logic opv_r, opv_nxt, olast_r, olast_nxt;

  logic wr_en;
  logic [IW-1:0] wr_addr, rd_addr;
  selq_pkg::entry_t wr_data, rd_data;

  logic out_free, accept;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || ov_r;
  assign accept = in_valid && !in_stall;

  selq_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    prev_shared_nxt = prev_shared_r;
    ov_nxt = ov_r && out_stall;
    ost_nxt = ost_r;
    ope_nxt = ope_r;
    opv_nxt = opv_r;
    olast_nxt = olast_r;
    wr_en = 1'b0;
    wr_addr = IW'(idx_r);
    wr_data = rd_data;
    rd_addr = IW'(idx_r);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = '0;
          unique case (selq_pkg::op_t'(in_opcode))
            selq_pkg::OP_LOCK: begin
              state_nxt = S_LREAD;
            end
            selq_pkg::OP_UNLOCK: begin
              state_nxt = S_UREAD;
            end
            selq_pkg::OP_SCAN: begin
              state_nxt = S_SREAD;
              prev_shared_nxt = 1'b1;
            end
            default: begin
              count_nxt = '0;
              ov_nxt = 1'b1;
              ost_nxt = selq_pkg::ST_CLEARED;
              opv_nxt = 1'b0;
              olast_nxt = 1'b1;
            end
          endcase
        end
      end
      S_LREAD: begin
        rd_addr = (count_r == '0) ? '0 : IW'(count_r - 1'b1);
        state_nxt = S_LDEC;
      end
      S_LDEC: begin
        if (out_free) begin
          logic grant;
          grant = (count_r == '0) ||
                  (shared_r && rd_data.shared && rd_data.granted);
          state_nxt = S_IDLE;
          ov_nxt = 1'b1;
          opv_nxt = 1'b0;
          olast_nxt = 1'b1;
          if (try_r && !grant) begin
            ost_nxt = selq_pkg::ST_HELD;
            if (notify_r && count_r != '0) begin
              ov_nxt = 1'b0;
              state_nxt = S_UCHK;
            end
          end else if (count_r == FULL_CNT) begin
            ost_nxt = selq_pkg::ST_FULL;
          end else begin
            ost_nxt = grant ? selq_pkg::ST_GRANTED : selq_pkg::ST_QUEUED;
            wr_en = 1'b1;
            wr_addr = IW'(count_r);
            wr_data = '{ref_w: ref_r, data_w: data_r, extra_w: extra_r,
                        shared: shared_r, granted: grant};
            count_nxt = count_r + 1'b1;
          end
        end
      end
      S_UREAD: begin
        if (idx_r >= count_r) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            ost_nxt = selq_pkg::ST_NOT_FOUND;
            opv_nxt = 1'b0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_UCHK;
        end
      end
      S_UCHK: begin
        if (op_r == selq_pkg::OP_LOCK) begin
          ope_nxt = rd_data;
          opv_nxt = 1'b1;
          ov_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else if (rd_data.ref_w == ref_r && rd_data.data_w == data_r) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            ost_nxt = rd_data.granted ? selq_pkg::ST_UNLOCKED
                                      : selq_pkg::ST_NOT_OWNER;
            ope_nxt = rd_data;
            opv_nxt = 1'b1;
            olast_nxt = 1'b1;
            count_nxt = count_r - 1'b1;
            state_nxt = S_SHREAD;
            if (idx_r + 1'b1 >= count_r) state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_UREAD;
        end
      end
      S_SHREAD: begin
        rd_addr = IW'(idx_r + 1'b1);
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        wr_en = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r + 1'b1 >= count_r) state_nxt = S_IDLE;
        else state_nxt = S_SHREAD;
      end
      S_SREAD: begin
        if (idx_r >= count_r) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            ost_nxt = selq_pkg::ST_SCAN_DONE;
            opv_nxt = 1'b0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (idx_r != '0 && !(prev_shared_r && rd_data.shared)) begin
          if (out_free) begin
            ov_nxt = 1'b1;
            ost_nxt = selq_pkg::ST_SCAN_DONE;
            opv_nxt = 1'b0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (out_free) begin
          prev_shared_nxt = rd_data.shared;
          if (!rd_data.granted) begin
            wr_en = 1'b1;
            wr_data.granted = 1'b1;
            ov_nxt = 1'b1;
            ost_nxt = selq_pkg::ST_NEW_GRANT;
            ope_nxt = rd_data;
            opv_nxt = 1'b1;
            olast_nxt = 1'b0;
          end
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SREAD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
    end
    idx_r <= idx_nxt;
    prev_shared_r <= prev_shared_nxt;
    ost_r <= ost_nxt;
    ope_r <= ope_nxt;
    opv_r <= opv_nxt;
    olast_r <= olast_nxt;
    if (accept) begin
      op_r <= in_opcode;
      ref_r <= in_requester_ref;
      data_r <= in_requester_data;
      extra_r <= in_extra_word;
      shared_r <= in_want_shared;
      try_r <= in_try_only;
      notify_r <= in_notify_owner;
    end
  end

  assign out_valid = ov_r;
  assign out_status = ost_r;
  assign out_peer_ref = opv_r ? ope_r.ref_w : '0;
  assign out_peer_data = opv_r ? ope_r.data_w : '0;
  assign out_peer_extra = opv_r ? ope_r.extra_w : '0;
  assign out_peer_shared = opv_r ? ope_r.shared : 1'b0;
  assign out_peer_valid = opv_r;
  assign out_last_result = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT) else $error("queue count exceeds depth");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> state_r == S_IDLE && !ov_r) else $error("accept while busy");
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_opcode == selq_pkg::OP_CLEAR |=> count_r == '0)
    else $error("clear did not empty queue");
endmodule

### hdl/selq_ram.sv
// Single-port-write, single-port-read queue entry memory, registered read.
// Depends on selq_pkg for the entry type and depth.
`timescale 1ns / 1ps
module selq_ram (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [selq_pkg::IDX_W-1:0] wr_addr,
  input  selq_pkg::entry_t       wr_data,
  input  logic [selq_pkg::IDX_W-1:0] rd_addr,
  output selq_pkg::entry_t       rd_data
);
  selq_pkg::entry_t mem [selq_pkg::QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
